[rtl/core/aou_pkg.sv]
package aou_pkg;

  // default element count
  localparam int unsigned NUM_ELEMENTS_DEF = 4096;

  // register map indexes (paddr[3:2])
  localparam logic [1:0] REG_LEARN_RATE   = 2'd0;
  localparam logic [1:0] REG_DECAY_FIRST  = 2'd1;
  localparam logic [1:0] REG_DECAY_SECOND = 2'd2;
  localparam logic [1:0] REG_EPSILON      = 2'd3;

  // register reset values
  localparam logic [23:0] LEARN_RATE_RST   = 24'd16777;
  localparam logic [15:0] DECAY_FIRST_RST  = 16'd58982;
  localparam logic [15:0] DECAY_SECOND_RST = 16'd65470;
  localparam logic [23:0] EPSILON_RST      = 24'd1;

  // one in Q1.16
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // iteration counts of the shared divider and the root unit
  localparam logic [6:0] DIV_MOMENT_ITERS = 7'd48;
  localparam logic [6:0] DIV_UPDATE_ITERS = 7'd40;
  localparam logic [6:0] SQRT_ITERS       = 7'd32;

  // sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_P1,
    ST_P2,
    ST_M1,
    ST_M2,
    ST_V1,
    ST_V2,
    ST_V3,
    ST_V4,
    ST_V5,
    ST_DIVM,
    ST_DIVV,
    ST_SQRT,
    ST_N1,
    ST_N2,
    ST_N3,
    ST_CAP,
    ST_DIVU,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

[rtl/core/aou_ram.sv]
module aou_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/adam_optimizer_update.sv]
// channel   direction  handshake           payload
// in_       input      in_valid/in_stall   element_index, param_value, gradient, end_of_step
// out_      output     out_valid/out_stall out_index, new_value, step_done
// apb       cfg        psel/penable/pready learn_rate, decay_first, decay_second, epsilon
//
// a transaction is taken in idle and runs as two 48-step divisions, a 32-step root, a
// 40-step division and 16 single steps on one shared divider and one shared 40x32
// multiplier; the last division is skipped when the update saturates, and the sequencer
// goes from the first moment step straight to output when the index is not below
// NUM_ELEMENTS
// after reset both moment memories are cleared, one entry a cycle, DEPTH entries in all
// (NUM_ELEMENTS, at most 4096); no transaction is taken meanwhile
// a finished result sits in the output register while the next transaction is taken;
// the sequencer waits in its last state while an earlier result is still stalled
module adam_optimizer_update #(
  parameter int unsigned NUM_ELEMENTS = aou_pkg::NUM_ELEMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        in_element_index,
  input  logic signed [31:0] in_param_value,
  input  logic signed [31:0] in_gradient,
  input  logic               in_end_of_step,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_index,
  output logic signed [31:0] out_new_value,
  output logic               out_step_done,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned DEPTH = (NUM_ELEMENTS > 4096) ? 4096 : NUM_ELEMENTS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  aou_pkg::state_t state_r, state_nxt;

  // configuration
  logic [23:0] learn_rate_r;
  logic [15:0] decay_first_r;
  logic [15:0] decay_second_r;
  logic [23:0] epsilon_r;

  // running powers
  logic [16:0] pow1_r, pow2_r;
  logic [16:0] p1_r, p2_r;

  // latched transaction
  logic [11:0]        idx_r;
  logic signed [31:0] value_r;
  logic [31:0]        gmag_r;
  logic               gneg_r;
  logic               eos_r;
  logic               in_range_r;

  // datapath
  logic [39:0] mul_a;
  logic [31:0] mul_b;
  logic [71:0] prod_r;
  logic [50:0] acc_r;
  logic [56:0] vacc_r;
  logic [38:0] g2_r;
  logic [31:0] mmag_r;
  logic        mneg_r;
  logic [31:0] v_r;
  logic [47:0] mhat_r;
  logic [39:0] den_r;
  logic [71:0] nacc_r;
  logic [40:0] upd_r;
  logic [31:0] result_r;

  // shared divider
  logic [40:0] div_rem_r;
  logic [71:0] div_q_r;
  logic [39:0] div_d_r;
  logic [6:0]  cnt_r;
  logic [40:0] div_t;
  logic        div_ge;
  logic [40:0] div_rem_step;
  logic [71:0] div_q_step;
  logic        cnt_last;

  // root unit
  logic [63:0] sq_x_r;
  logic [35:0] sq_rem_r;
  logic [31:0] sq_root_r;
  logic        sq_big_r;
  logic [35:0] sq_t;
  logic [35:0] sq_trial;
  logic        sq_ge;
  logic [35:0] sq_rem_step;
  logic [31:0] sq_root_step;
  logic        vhat_big;

  // memories
  logic [AW-1:0] clr_cnt_r;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   m_wdata, v_wdata;
  logic          ram_re;
  logic [31:0]   m_q, v_q;

  // misc combinational
  logic        in_fire, out_fire, cfg_wr;
  logic [16:0] c1, c2;
  logic [31:0] m_q_mag;
  logic [50:0] m_term;
  logic [50:0] acc_mag;
  logic [50:0] acc_rnd;
  logic [32:0] m_new_mag;
  logic [63:0] g2_rnd;
  logic [56:0] v_rnd;
  logic [31:0] v_new;
  logic [16:0] corr1, corr2;
  logic [35:0] root36;
  logic [39:0] den_sum;
  logic [42:0] res_wide;
  logic signed [42:0] res_s;
  logic [31:0] result_nxt;
  logic [31:0] m_signed;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  assign c1    = aou_pkg::ONE_Q16 - {1'b0, decay_first_r};
  assign c2    = aou_pkg::ONE_Q16 - {1'b0, decay_second_r};
  assign corr1 = aou_pkg::ONE_Q16 - p1_r;
  assign corr2 = aou_pkg::ONE_Q16 - p2_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r   <= aou_pkg::LEARN_RATE_RST;
      decay_first_r  <= aou_pkg::DECAY_FIRST_RST;
      decay_second_r <= aou_pkg::DECAY_SECOND_RST;
      epsilon_r      <= aou_pkg::EPSILON_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        aou_pkg::REG_LEARN_RATE:   learn_rate_r   <= pwdata[23:0];
        aou_pkg::REG_DECAY_FIRST:  decay_first_r  <= pwdata[15:0];
        aou_pkg::REG_DECAY_SECOND: decay_second_r <= pwdata[15:0];
        aou_pkg::REG_EPSILON:      epsilon_r      <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (paddr[3:2])
      aou_pkg::REG_LEARN_RATE:   prdata = {8'h0, learn_rate_r};
      aou_pkg::REG_DECAY_FIRST:  prdata = {16'h0, decay_first_r};
      aou_pkg::REG_DECAY_SECOND: prdata = {16'h0, decay_second_r};
      aou_pkg::REG_EPSILON:      prdata = {8'h0, epsilon_r};
      default:                   prdata = 32'h0;
    endcase
  end

  // moment memories
  aou_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_first_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (m_wdata),
    .rd_en   (ram_re),
    .rd_addr (in_element_index[AW-1:0]),
    .rd_data (m_q)
  );

  aou_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_second_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (v_wdata),
    .rd_en   (ram_re),
    .rd_addr (in_element_index[AW-1:0]),
    .rd_data (v_q)
  );

  // divider step
  assign div_t        = {div_rem_r[39:0], div_q_r[71]};
  assign div_ge       = div_t >= {1'b0, div_d_r};
  assign div_rem_step = div_ge ? (div_t - {1'b0, div_d_r}) : div_t;
  assign div_q_step   = {div_q_r[70:0], div_ge};
  assign cnt_last     = (cnt_r == 7'd1);

  // root step
  assign sq_t         = {sq_rem_r[33:0], sq_x_r[63:62]};
  assign sq_trial     = {2'b00, sq_root_r, 2'b01};
  assign sq_ge        = sq_t >= sq_trial;
  assign sq_rem_step  = sq_ge ? (sq_t - sq_trial) : sq_t;
  assign sq_root_step = {sq_root_r[30:0], sq_ge};
  assign vhat_big     = |div_q_step[47:40];

  // first moment arithmetic
  assign m_q_mag   = m_q[31] ? (32'h0 - m_q) : m_q;
  assign m_term    = (gneg_r ? (51'h0 - {1'b0, prod_r[49:0]}) : {1'b0, prod_r[49:0]});
  assign acc_mag   = acc_r[50] ? (51'h0 - acc_r) : acc_r;
  assign acc_rnd   = acc_mag + 51'd32768;
  assign m_new_mag = acc_rnd[48:16];
  assign m_signed  = mneg_r ? (32'h0 - mmag_r) : mmag_r;

  // second moment arithmetic
  assign g2_rnd = prod_r[63:0] + 64'h80_0000;
  assign v_rnd  = vacc_r + 57'd32768;
  assign v_new  = (|v_rnd[56:48]) ? 32'hFFFF_FFFF : v_rnd[47:16];

  // denominator
  assign root36  = sq_big_r ? {sq_root_r, 4'h0} : {4'h0, sq_root_r};
  assign den_sum = {4'h0, root36} + {16'h0, epsilon_r};

  // final saturation
  assign res_wide = mneg_r ? ({{11{value_r[31]}}, value_r} + {2'b00, upd_r})
                           : ({{11{value_r[31]}}, value_r} - {2'b00, upd_r});
  assign res_s    = signed'(res_wide);
  always_comb begin
    if (res_s > 43'sd2147483647) begin
      result_nxt = 32'h7FFF_FFFF;
    end else if (res_s < -43'sd2147483648) begin
      result_nxt = 32'h8000_0000;
    end else begin
      result_nxt = res_wide[31:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aou_pkg::ST_CLEAR: if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = aou_pkg::ST_IDLE;
      aou_pkg::ST_IDLE:  if (in_valid) state_nxt = aou_pkg::ST_P1;
      aou_pkg::ST_P1:    state_nxt = aou_pkg::ST_P2;
      aou_pkg::ST_P2:    state_nxt = aou_pkg::ST_M1;
      aou_pkg::ST_M1:    state_nxt = in_range_r ? aou_pkg::ST_M2 : aou_pkg::ST_OUT;
      aou_pkg::ST_M2:    state_nxt = aou_pkg::ST_V1;
      aou_pkg::ST_V1:    state_nxt = aou_pkg::ST_V2;
      aou_pkg::ST_V2:    state_nxt = aou_pkg::ST_V3;
      aou_pkg::ST_V3:    state_nxt = aou_pkg::ST_V4;
      aou_pkg::ST_V4:    state_nxt = aou_pkg::ST_V5;
      aou_pkg::ST_V5:    state_nxt = aou_pkg::ST_DIVM;
      aou_pkg::ST_DIVM:  if (cnt_last) state_nxt = aou_pkg::ST_DIVV;
      aou_pkg::ST_DIVV:  if (cnt_last) state_nxt = aou_pkg::ST_SQRT;
      aou_pkg::ST_SQRT:  if (cnt_last) state_nxt = aou_pkg::ST_N1;
      aou_pkg::ST_N1:    state_nxt = aou_pkg::ST_N2;
      aou_pkg::ST_N2:    state_nxt = aou_pkg::ST_N3;
      aou_pkg::ST_N3:    state_nxt = aou_pkg::ST_CAP;
      aou_pkg::ST_CAP:   state_nxt = (nacc_r[71:40] >= den_r[31:0] || |den_r[39:32]) ?
                                     ((nacc_r[71:40] >= den_r[31:0] && ~|den_r[39:32]) ?
                                      aou_pkg::ST_FIN : aou_pkg::ST_DIVU) :
                                     aou_pkg::ST_DIVU;
      aou_pkg::ST_DIVU:  if (cnt_last) state_nxt = aou_pkg::ST_FIN;
      aou_pkg::ST_FIN:   state_nxt = aou_pkg::ST_OUT;
      aou_pkg::ST_OUT:   if (!out_valid || !out_stall) state_nxt = aou_pkg::ST_IDLE;
      default:           state_nxt = aou_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, multiplier operands, memory ports
  always_comb begin
    in_stall  = (state_r != aou_pkg::ST_IDLE);
    ram_re    = in_valid && (state_r == aou_pkg::ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = idx_r[AW-1:0];
    m_wdata   = m_signed;
    v_wdata   = v_new;
    mul_a     = 40'h0;
    mul_b     = 32'h0;
    unique case (state_r)
      aou_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        m_wdata   = 32'h0;
        v_wdata   = 32'h0;
      end
      aou_pkg::ST_P1: begin
        mul_a = {23'h0, pow1_r};
        mul_b = {16'h0, decay_first_r};
      end
      aou_pkg::ST_P2: begin
        mul_a = {23'h0, pow2_r};
        mul_b = {16'h0, decay_second_r};
      end
      aou_pkg::ST_M1: begin
        mul_a = {8'h0, m_q_mag};
        mul_b = {16'h0, decay_first_r};
      end
      aou_pkg::ST_M2: begin
        mul_a = {8'h0, gmag_r};
        mul_b = {15'h0, c1};
      end
      aou_pkg::ST_V1: begin
        mul_a = {8'h0, gmag_r};
        mul_b = gmag_r;
      end
      aou_pkg::ST_V2: begin
        mul_a = {8'h0, v_q};
        mul_b = {16'h0, decay_second_r};
      end
      aou_pkg::ST_V3: begin
        mul_a = {1'b0, g2_r};
        mul_b = {15'h0, c2};
      end
      aou_pkg::ST_V5: ram_we = 1'b1;
      aou_pkg::ST_N1: begin
        mul_a = {16'h0, mhat_r[47:24]};
        mul_b = {8'h0, learn_rate_r};
      end
      aou_pkg::ST_N2: begin
        mul_a = {16'h0, mhat_r[23:0]};
        mul_b = {8'h0, learn_rate_r};
      end
      default: ;
    endcase
  end

  // shared multiplier, product registered
  always_ff @(posedge clk) begin
    prod_r <= 72'(mul_a) * 72'(mul_b);
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= aou_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
      pow1_r    <= aou_pkg::ONE_Q16;
      pow2_r    <= aou_pkg::ONE_Q16;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == aou_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (state_r == aou_pkg::ST_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        if (eos_r) begin
          pow1_r <= p1_r;
          pow2_r <= p2_r;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == aou_pkg::ST_OUT && (!out_valid || !out_stall)) begin
      out_index     <= idx_r;
      out_new_value <= signed'(result_r);
      out_step_done <= eos_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx_r      <= in_element_index;
      value_r    <= in_param_value;
      gneg_r     <= in_gradient[31];
      gmag_r     <= in_gradient[31] ? (32'h0 - in_gradient) : in_gradient;
      eos_r      <= in_end_of_step;
      in_range_r <= (32'(in_element_index) < NUM_ELEMENTS);
    end
    case (state_r)
      aou_pkg::ST_P2: p1_r <= prod_r[32:16];
      aou_pkg::ST_M1: begin
        p2_r     <= prod_r[32:16];
        result_r <= value_r;
      end
      aou_pkg::ST_M2: acc_r <= m_q[31] ? (51'h0 - {1'b0, prod_r[49:0]})
                                       : {1'b0, prod_r[49:0]};
      aou_pkg::ST_V1: acc_r <= acc_r + m_term;
      aou_pkg::ST_V2: begin
        mmag_r <= m_new_mag[31:0];
        mneg_r <= acc_r[50] && (|m_new_mag);
        g2_r   <= g2_rnd[62:24];
      end
      aou_pkg::ST_V3: vacc_r <= prod_r[56:0];
      aou_pkg::ST_V4: vacc_r <= vacc_r + prod_r[56:0];
      aou_pkg::ST_V5: begin
        v_r       <= v_new;
        div_rem_r <= '0;
        div_q_r   <= {mmag_r, 40'h0};
        div_d_r   <= {23'h0, corr1};
        cnt_r     <= aou_pkg::DIV_MOMENT_ITERS;
      end
      aou_pkg::ST_DIVM: begin
        if (cnt_last) begin
          mhat_r    <= div_q_step[47:0];
          div_rem_r <= '0;
          div_q_r   <= {v_r, 40'h0};
          div_d_r   <= {23'h0, corr2};
          cnt_r     <= aou_pkg::DIV_MOMENT_ITERS;
        end else begin
          div_rem_r <= div_rem_step;
          div_q_r   <= div_q_step;
          cnt_r     <= cnt_r - 7'd1;
        end
      end
      aou_pkg::ST_DIVV: begin
        if (cnt_last) begin
          sq_big_r  <= vhat_big;
          sq_x_r    <= vhat_big ? {div_q_step[47:0], 16'h0} : {div_q_step[39:0], 24'h0};
          sq_rem_r  <= '0;
          sq_root_r <= '0;
          cnt_r     <= aou_pkg::SQRT_ITERS;
        end else begin
          div_rem_r <= div_rem_step;
          div_q_r   <= div_q_step;
          cnt_r     <= cnt_r - 7'd1;
        end
      end
      aou_pkg::ST_SQRT: begin
        sq_rem_r  <= sq_rem_step;
        sq_root_r <= sq_root_step;
        sq_x_r    <= {sq_x_r[61:0], 2'b00};
        cnt_r     <= cnt_r - 7'd1;
      end
      aou_pkg::ST_N1: den_r <= (den_sum == 40'h0) ? 40'h1 : den_sum;
      aou_pkg::ST_N2: nacc_r <= {prod_r[47:0], 24'h0};
      aou_pkg::ST_N3: nacc_r <= nacc_r + {24'h0, prod_r[47:0]};
      aou_pkg::ST_CAP: begin
        upd_r     <= 41'h100_0000_0000;
        div_rem_r <= {9'h0, nacc_r[71:40]};
        div_q_r   <= {nacc_r[39:0], 32'h0};
        div_d_r   <= den_r;
        cnt_r     <= aou_pkg::DIV_UPDATE_ITERS;
      end
      aou_pkg::ST_DIVU: begin
        div_rem_r <= div_rem_step;
        div_q_r   <= div_q_step;
        cnt_r     <= cnt_r - 7'd1;
        if (cnt_last) begin
          upd_r <= {1'b0, div_q_step[39:0]};
        end
      end
      aou_pkg::ST_FIN: result_r <= result_nxt;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // an accepted transaction starts the sequencer on the next cycle
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == aou_pkg::ST_P1))
    else $error("sequencer did not start after accept");

  // running powers never exceed one
  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pow1_r <= aou_pkg::ONE_Q16) && (pow2_r <= aou_pkg::ONE_Q16))
    else $error("decay power above one");

  // the update is capped before it reaches the result
  a_update_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aou_pkg::ST_FIN) |-> (upd_r <= 41'h100_0000_0000))
    else $error("update beyond cap");

  // iteration counter never runs out inside an iterative state
  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aou_pkg::ST_DIVM || state_r == aou_pkg::ST_DIVV ||
     state_r == aou_pkg::ST_SQRT || state_r == aou_pkg::ST_DIVU) |-> (cnt_r != 7'd0))
    else $error("iteration counter exhausted");
`endif

endmodule

[bench/tb_adam_optimizer_update.sv]
`timescale 1ns / 100ps

module tb_adam_optimizer_update;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES  = 250;
  localparam int unsigned PHASE_ITEMS    = 240;

  // expected result of one transaction
  typedef struct {
    bit [11:0]        index;
    bit signed [31:0] value;
    bit               done;
  } update_t;

  // mirror of the optimiser state, predicts each updated value
  class update_scoreboard;
    bit [23:0]        learn_rate;
    bit [15:0]        decay_first;
    bit [15:0]        decay_second;
    bit [23:0]        epsilon;
    bit signed [31:0] first_moment [4096];
    bit [31:0]        second_moment [4096];
    bit [63:0]        first_power;
    bit [63:0]        second_power;
    update_t          pending_updates [$];
    int               errors;

    function new();
      learn_rate   = aou_pkg::LEARN_RATE_RST;
      decay_first  = aou_pkg::DECAY_FIRST_RST;
      decay_second = aou_pkg::DECAY_SECOND_RST;
      epsilon      = aou_pkg::EPSILON_RST;
      foreach (first_moment[i]) begin
        first_moment[i]  = '0;
        second_moment[i] = '0;
      end
      first_power  = 64'd65536;
      second_power = 64'd65536;
      errors       = 0;
    endfunction

    function void set_register(bit [1:0] reg_idx, bit [31:0] data);
      case (reg_idx)
        aou_pkg::REG_LEARN_RATE:   learn_rate   = data[23:0];
        aou_pkg::REG_DECAY_FIRST:  decay_first  = data[15:0];
        aou_pkg::REG_DECAY_SECOND: decay_second = data[15:0];
        aou_pkg::REG_EPSILON:      epsilon      = data[23:0];
        default: ;
      endcase
    endfunction

    static function bit [63:0] int_sqrt(bit [63:0] x);
      bit [63:0] res;
      bit [63:0] bitpos;
      res    = '0;
      bitpos = 64'd1 << 62;
      while (bitpos > x) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
        if (x >= res + bitpos) begin
          x   = x - (res + bitpos);
          res = (res >> 1) + bitpos;
        end else begin
          res = res >> 1;
        end
        bitpos = bitpos >> 2;
      end
      return res;
    endfunction

    function bit signed [31:0] predict_value(bit [11:0] idx, bit signed [31:0] val,
                                             bit signed [31:0] grad, bit eos);
      bit [63:0] p1, p2, mag, gm, g2, vsum, v_new, mabs, mhat, vhat, root, den;
      bit [63:0] hi, lo, a, q1, r1, b, upd;
      longint    msum, m_new, res;
      p1   = (first_power * decay_first) >> 16;
      p2   = (second_power * decay_second) >> 16;
      // moment blends
      msum = longint'(decay_first) * longint'(first_moment[idx]) +
             longint'(65536 - int'(decay_first)) * longint'(grad);
      mag  = (msum < 0) ? 64'(-msum) : 64'(msum);
      mag  = (mag + 64'd32768) >> 16;
      m_new = (msum < 0) ? -longint'(mag) : longint'(mag);
      gm   = (grad < 0) ? 64'(-longint'(grad)) : 64'(longint'(grad));
      g2   = (gm * gm + (64'd1 << 23)) >> 24;
      vsum = 64'(decay_second) * 64'(second_moment[idx]) +
             64'(65536 - int'(decay_second)) * g2;
      v_new = (vsum + 64'd32768) >> 16;
      if (v_new > 64'hFFFF_FFFF) v_new = 64'hFFFF_FFFF;
      first_moment[idx]  = m_new[31:0];
      second_moment[idx] = v_new[31:0];
      // bias correction and root
      mabs = (m_new < 0) ? 64'(-m_new) : 64'(m_new);
      mhat = (mabs << 16) / (64'd65536 - p1);
      vhat = (v_new << 16) / (64'd65536 - p2);
      if (vhat < (64'd1 << 40)) root = int_sqrt(vhat << 24);
      else root = int_sqrt(vhat << 16) << 4;
      den = root + 64'(epsilon);
      if (den == 0) den = 64'd1;
      // lr * m_hat / den in two parts
      hi = mhat >> 24;
      lo = mhat & 64'hFF_FFFF;
      a  = 64'(learn_rate) * hi;
      q1 = a / den;
      r1 = a % den;
      b  = (r1 << 24) + 64'(learn_rate) * lo;
      if (q1 >= (64'd1 << 33)) upd = 64'd1 << 40;
      else upd = (q1 << 24) + b / den;
      if (upd > (64'd1 << 40)) upd = 64'd1 << 40;
      res = (m_new < 0) ? longint'(val) + longint'(upd) : longint'(val) - longint'(upd);
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      if (eos) begin
        first_power  = p1;
        second_power = p2;
      end
      return res[31:0];
    endfunction

    function void note_input(bit [11:0] idx, bit signed [31:0] val,
                             bit signed [31:0] grad, bit eos);
      update_t u;
      u.index = idx;
      u.value = predict_value(idx, val, grad, eos);
      u.done  = eos;
      pending_updates = {pending_updates, u};
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(bit [11:0] idx, bit signed [31:0] val, bit done);
      update_t u;
      if (pending_updates.size() == 0) begin
        report($sformatf("unexpected result index %0d value %0d", idx, val));
      end else begin
        u = pending_updates.pop_front();
        if (idx !== u.index)
          report($sformatf("out_index %0d, expected %0d", idx, u.index));
        if (val !== u.value)
          report($sformatf("new_value %0d, expected %0d (index %0d)", val, u.value, u.index));
        if (done !== u.done)
          report($sformatf("step_done %0b, expected %0b", done, u.done));
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [11:0]        in_element_index;
  logic signed [31:0] in_param_value;
  logic signed [31:0] in_gradient;
  logic               in_end_of_step;
  logic               out_valid;
  logic               out_stall;
  logic [11:0]        out_index;
  logic signed [31:0] out_new_value;
  logic               out_step_done;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  update_scoreboard sb;
  bit               no_idle;
  int unsigned      quiet_cycles;

  adam_optimizer_update u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_element_index(in_element_index), .in_param_value(in_param_value),
    .in_gradient(in_gradient), .in_end_of_step(in_end_of_step),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_index(out_index), .out_new_value(out_new_value), .out_step_done(out_step_done),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // result side back-pressure
  always @(negedge clk) begin
    out_stall = !no_idle && ($urandom_range(99) < 6);
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (in_valid && !in_stall)
      sb.note_input(in_element_index, in_param_value, in_gradient, in_end_of_step);
    if (out_valid && !out_stall)
      sb.check_result(out_index, out_new_value, out_step_done);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task write_register(bit [1:0] reg_idx, bit [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {reg_idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    sb.set_register(reg_idx, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task write_all(bit [23:0] lr, bit [15:0] b1, bit [15:0] b2, bit [23:0] eps);
    write_register(aou_pkg::REG_LEARN_RATE, 32'(lr));
    write_register(aou_pkg::REG_DECAY_FIRST, 32'(b1));
    write_register(aou_pkg::REG_DECAY_SECOND, 32'(b2));
    write_register(aou_pkg::REG_EPSILON, 32'(eps));
  endtask

  // one input transaction, with an occasional idle gap first
  task send_item(bit [11:0] idx, bit signed [31:0] val, bit signed [31:0] grad, bit eos);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 6) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_element_index = idx;
    in_param_value   = val;
    in_gradient      = grad;
    in_end_of_step   = eos;
    do @(posedge clk); while (in_stall);
  endtask

  // let every expected result arrive and the sequencer settle
  task drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_updates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task random_item;
    bit [11:0]        idx;
    bit signed [31:0] val;
    bit signed [31:0] grad;
    if ($urandom_range(99) < 75) begin
      // well-formed training traffic over a small working set
      idx  = 12'($urandom_range(15)) | ($urandom_range(1) ? 12'hFF0 : 12'h000);
      val  = 32'(int'($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
      grad = 32'(int'($urandom_range(32'h0200_0000)) - 32'sh0100_0000);
      send_item(idx, val, grad, $urandom_range(15) == 0);
    end else begin
      send_item(12'($urandom), 32'($urandom), 32'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_element_index = '0;
    in_param_value   = '0;
    in_gradient      = '0;
    in_end_of_step   = 1'b0;
    out_stall        = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    no_idle          = 1'b0;
    quiet_cycles     = 0;
    sb               = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes under reset settings
    send_item(12'd0, 32'sh0100_0000, 32'sh0010_0000, 1'b0);
    send_item(12'd4095, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    send_item(12'd1, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    send_item(12'd2, 32'sh0000_0000, 32'sh0000_0000, 1'b0);
    send_item(12'd0, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b1);
    send_item(12'd4095, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    send_item(12'd3, 32'sh7FFF_FFFF, 32'sh0000_0001, 1'b0);
    drain();

    // directed: zero epsilon with a zero root, extreme decays, maximum rate
    write_all(24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 24'd0);
    send_item(12'd100, 32'sh0123_4567, 32'sh0000_0000, 1'b0);
    send_item(12'd101, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    send_item(12'd102, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    send_item(12'd101, 32'sh0000_0000, 32'sh0000_0001, 1'b1);
    drain();
    write_all(24'd0, 16'd0, 16'd0, 24'hFF_FFFF);
    send_item(12'd200, 32'sh1234_5678, 32'sh7FFF_FFFF, 1'b1);
    send_item(12'd201, 32'sh8765_4321, 32'sh8000_0000, 1'b0);
    drain();
    write_all(24'hFF_FFFF, 16'd0, 16'd0, 24'd1);
    send_item(12'd300, 32'sh0000_0000, 32'sh8000_0000, 1'b1);
    send_item(12'd301, 32'sh7FFF_FFFF, 32'sh0000_0100, 1'b0);
    drain();

    // random phases, each under its own settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(aou_pkg::LEARN_RATE_RST, aou_pkg::DECAY_FIRST_RST,
                     aou_pkg::DECAY_SECOND_RST, aou_pkg::EPSILON_RST);
        1: write_all(24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 24'd1);
        2: write_all(24'd0, 16'd0, 16'd0, 24'hFF_FFFF);
        default: write_all(24'($urandom), 16'($urandom), 16'($urandom),
                           24'($urandom_range(24'hFF_FFFF, 1)));
      endcase
      no_idle = (ph == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
      drain();
      no_idle = 1'b0;
    end

    if (sb.errors == 0 && sb.pending_updates.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
